FILE: hdl/ksm_pkg.sv
// Shared types, widths and register indexes for the stream pattern matcher.
// Used by ksm_cell and kmp_stream_matcher_core.
package ksm_pkg;

    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 5;
    localparam int REG_BYTES  = 16;
    localparam int BIDX_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_W      = REG_BYTES * CHAR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

    typedef struct packed {
        logic              step;   // advance every cell
        logic              flush;  // ignore held state (start of a new text)
        logic              clear;  // zero every cell
        logic [CHAR_W-1:0] sym;    // byte presented to the row
    } t_cell_ctrl;

    // Length in use: zero means one, capped at the number of cells.
    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] raw,
                                                    input logic [LEN_W-1:0] cap);
        logic [LEN_W-1:0] len;
        len = raw;
        if (raw == '0) begin
            len = LEN_W'(1);
        end else if (raw > cap) begin
            len = cap;
        end
        return len;
    endfunction

endpackage

FILE: hdl/ksm_cell.sv
// One cell of the matcher row: holds whether a pattern prefix ends at the current byte.
// Depends on ksm_pkg.
module ksm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ksm_pkg::t_cell_ctrl       i_ctrl,
    input  logic                      i_head,
    input  logic                      i_prev,
    input  logic                      i_keep,
    input  logic [ksm_pkg::CHAR_W-1:0] i_pat,
    output logic                      o_raw,
    output logic                      o_state
);
    import ksm_pkg::*;

    logic r_state;
    logic n_state;

    assign o_raw = (i_head | (i_prev & ~i_ctrl.flush)) & (i_pat == i_ctrl.sym);

    always_comb begin
        n_state = r_state;
        if (i_ctrl.clear) begin
            n_state = 1'b0;
        end else if (i_ctrl.step) begin
            n_state = o_raw & i_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= 1'b0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

FILE: hdl/kmp_stream_matcher_core.sv
// Top level of the stream pattern matcher: a row of compare cells plus config and replay control.
// Depends on ksm_pkg and ksm_cell.
//
// Searches a byte stream for a configured pattern of 1 to 16 bytes, one text byte per cycle
// unless replaying or stalled by the result side: each cell compares the incoming byte with its
// pattern byte and hands its match bit to the next cell; a word's result is registered and
// appears in the next cycle. Match progress survives register writes. After a configuration
// write that leaves the held progress nonzero and below the pattern length, the row rebuilds
// its state by replaying that many pattern bytes, one per cycle unless a register write
// restarts it, taking no text word meanwhile. Write registers only while no word is in flight.
module kmp_stream_matcher_core #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ksm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ksm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] text_char
    input  logic                          s_axis_tuser,  // [0] first_of_text
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata   // [4:0] matched_length, [5] hit,
                                                         // [6] found, [7] zero
);
    import ksm_pkg::*;

    localparam int NCELL = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam logic [LEN_W-1:0] CAP = LEN_W'(NCELL);

    logic [LEN_W-1:0]  r_len_raw;
    logic [PAT_W-1:0]  r_pattern;
    logic [LEN_W-1:0]  r_progress;
    logic              r_found;
    logic              r_busy;
    logic [BIDX_W-1:0] r_ridx;
    logic              r_out_valid;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_hit;
    logic              r_out_found;

    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  n_len_raw;
    logic [LEN_W-1:0]  n_eff_len;
    logic [LEN_W-1:0]  q_trunc;
    logic              cfg_hit;
    logic              accept;
    logic              replay_step;
    logic [CHAR_W-1:0] replay_byte;
    t_cell_ctrl        ctrl;
    logic [NCELL-1:0]  keep;
    logic [NCELL-1:0]  last_sel;
    logic [NCELL-1:0]  raw;
    logic [NCELL-1:0]  state;
    logic [LEN_W-1:0]  n_matched;
    logic              n_hit;

    assign eff_len = eff_length(r_len_raw, CAP);

    always_comb begin
        cfg_hit   = 1'b0;
        n_len_raw = r_len_raw;
        case (i_cfg_idx)
            CFG_PATTERN_LENGTH: begin
                cfg_hit   = i_cfg_we;
                n_len_raw = i_cfg_we ? i_cfg_data[LEN_W-1:0] : r_len_raw;
            end
            CFG_PATTERN_LOW:  cfg_hit = i_cfg_we;
            CFG_PATTERN_HIGH: cfg_hit = i_cfg_we;
            default:          cfg_hit = 1'b0;
        endcase
    end

    assign n_eff_len = eff_length(n_len_raw, CAP);
    assign q_trunc   = (r_progress >= n_eff_len) ? '0 : r_progress;

    assign s_axis_tready = ~r_busy & (~r_out_valid | m_axis_tready);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign replay_step   = r_busy & ~cfg_hit;
    assign replay_byte   = r_pattern[{r_ridx, 3'b000} +: CHAR_W];

    assign ctrl.step  = accept | replay_step;
    assign ctrl.flush = accept & s_axis_tuser;
    assign ctrl.clear = cfg_hit;
    assign ctrl.sym   = r_busy ? replay_byte : s_axis_tdata;

    genvar k;
    generate
        for (k = 0; k < NCELL; k++) begin : g_cell
            assign keep[k]     = (LEN_W'(k + 1) < eff_len);
            assign last_sel[k] = (LEN_W'(k + 1) == eff_len);
            if (k == 0) begin : g_head
                ksm_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (ctrl),
                    .i_head  (1'b1),
                    .i_prev  (1'b0),
                    .i_keep  (keep[k]),
                    .i_pat   (r_pattern[k*CHAR_W +: CHAR_W]),
                    .o_raw   (raw[k]),
                    .o_state (state[k])
                );
            end else begin : g_body
                ksm_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (ctrl),
                    .i_head  (1'b0),
                    .i_prev  (state[k-1]),
                    .i_keep  (keep[k]),
                    .i_pat   (r_pattern[k*CHAR_W +: CHAR_W]),
                    .o_raw   (raw[k]),
                    .o_state (state[k])
                );
            end
        end
    endgenerate

    always_comb begin
        n_matched = '0;
        for (int j = 0; j < NCELL; j++) begin
            if (raw[j] & keep[j]) begin
                n_matched = LEN_W'(j + 1);
            end
        end
    end

    assign n_hit = |(raw & last_sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_raw   <= LEN_W'(1);
            r_pattern   <= '0;
            r_progress  <= '0;
            r_found     <= 1'b0;
            r_busy      <= 1'b0;
            r_ridx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_hit) begin
                // progress is held as is; a value at or past the length reads as zero
                r_len_raw <= n_len_raw;
                r_busy    <= (q_trunc != '0);
                r_ridx    <= '0;
                case (i_cfg_idx)
                    CFG_PATTERN_LOW:  r_pattern[CFG_DATA_W-1:0] <= i_cfg_data;
                    CFG_PATTERN_HIGH: r_pattern[PAT_W-1:CFG_DATA_W] <= i_cfg_data;
                    default:          r_pattern <= r_pattern;
                endcase
            end else if (replay_step) begin
                r_ridx <= r_ridx + BIDX_W'(1);
                if (({1'b0, r_ridx} + LEN_W'(1)) == r_progress) begin
                    r_busy <= 1'b0;
                end
            end else if (accept) begin
                r_progress <= n_matched;
                r_found    <= (r_found & ~s_axis_tuser) | n_hit;
            end

            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_len   <= n_matched;
            r_out_hit   <= n_hit;
            r_out_found <= (r_found & ~s_axis_tuser) | n_hit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_found, r_out_hit, r_out_len};

`ifndef SYNTH
    a_no_accept_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_axis_tready)
        else $error("text word taken during replay");

    a_hit_sets_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_hit) |=> r_found)
        else $error("hit did not set found");

    a_replay_len_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_progress != '0) && (r_progress < eff_len)))
        else $error("replay length not within pattern length");

    a_cells_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state & ~keep) == '0)
        else $error("cell set at or beyond pattern length");
`endif

endmodule

FILE: dv/kmp_match_checker.sv
// Result checker for kmp_stream_matcher_core: follows register writes, predicts every
// result word from the accepted text words and compares it field by field.
// Depends on ksm_pkg.
module kmp_match_checker #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ksm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ksm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [7:0]                     i_s_tdata,  // [7:0] text_char
    input  logic                           i_s_tuser,  // [0] first_of_text
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [7:0]                     i_m_tdata,  // [4:0] matched_length, [5] hit,
                                                       // [6] found, [7] zero
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_hits
);

    localparam int LW  = ksm_pkg::LEN_W;
    localparam int CAP = (MAX_PATTERN < ksm_pkg::REG_BYTES) ? MAX_PATTERN : ksm_pkg::REG_BYTES;

    typedef struct packed {
        logic          found;
        logic          hit;
        logic [LW-1:0] matched_len;
    } t_match_word;

    logic [LW-1:0] len_reg = LW'(1);
    logic [63:0]   pat_lo  = '0;
    logic [63:0]   pat_hi  = '0;
    logic [LW-1:0] progress = '0;
    logic          found_q  = 1'b0;
    logic [LW-1:0] prefix_fn [ksm_pkg::REG_BYTES];
    t_match_word   expected_q [$];

    int mismatches = 0;
    int pending    = 0;
    int checked    = 0;
    int hits       = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_hits       = hits;

    function automatic int len_in_use();
        int n;
        n = len_reg;
        if (n == 0) n = 1;
        if (n > CAP) n = CAP;
        return n;
    endfunction

    function automatic logic [7:0] pat_byte(input int k);
        if (k < 8) return pat_lo[8*k +: 8];
        if (k < 16) return pat_hi[8*(k-8) +: 8];
        return 8'h00;
    endfunction

    // Standard prefix function over the bytes in use.
    function automatic void build_prefix_fn();
        int n;
        int q;
        n = len_in_use();
        q = 0;
        for (int i = 0; i < ksm_pkg::REG_BYTES; i++) prefix_fn[i] = '0;
        for (int i = 1; i < n; i++) begin
            while (q > 0 && pat_byte(i) != pat_byte(q)) q = prefix_fn[q-1];
            if (pat_byte(i) == pat_byte(q)) q++;
            prefix_fn[i] = LW'(q);
        end
    endfunction

    function automatic t_match_word kmp_advance(input logic [7:0] c, input logic first);
        t_match_word r;
        int n;
        int q;
        n = len_in_use();
        if (first) begin
            progress = '0;
            found_q  = 1'b0;
        end
        q = progress;
        if (q >= n) q = 0;
        while (q > 0 && pat_byte(q) != c) q = prefix_fn[q-1];
        if (pat_byte(q) == c) q++;
        r.hit = 1'b0;
        if (q == n) begin
            r.hit   = 1'b1;
            found_q = 1'b1;
            q       = prefix_fn[n-1];
        end
        progress      = LW'(q);
        r.matched_len = progress;
        r.found       = found_q;
        return r;
    endfunction

    task automatic note_mismatch(input t_match_word want, input logic [7:0] raw, input bit lone);
        mismatches++;
        if (mismatches <= 10) begin
            if (lone) begin
                $display("mismatch: result word %02h with nothing expected", raw);
            end else begin
                $display("mismatch at result %0d: expected len=%0d hit=%0b found=%0b",
                         checked, want.matched_len, want.hit, want.found);
                $display("    got len=%0d hit=%0b found=%0b pad=%0b",
                         raw[4:0], raw[5], raw[6], raw[7]);
            end
        end
    endtask

    initial build_prefix_fn();

    always @(posedge i_clk) begin
        t_match_word want;
        t_match_word got;
        if (!i_rst_n) begin
            len_reg  = LW'(1);
            pat_lo   = '0;
            pat_hi   = '0;
            progress = '0;
            found_q  = 1'b0;
            build_prefix_fn();
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ksm_pkg::CFG_PATTERN_LENGTH: len_reg = i_cfg_data[LW-1:0];
                    ksm_pkg::CFG_PATTERN_LOW:    pat_lo  = i_cfg_data;
                    ksm_pkg::CFG_PATTERN_HIGH:   pat_hi  = i_cfg_data;
                    default: ;
                endcase
                build_prefix_fn();
            end
            if (i_s_tvalid && i_s_tready) begin
                want = kmp_advance(i_s_tdata, i_s_tuser);
                expected_q.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.matched_len = i_m_tdata[4:0];
                got.hit         = i_m_tdata[5];
                got.found       = i_m_tdata[6];
                if (expected_q.size() == 0) begin
                    note_mismatch(got, i_m_tdata, 1'b1);
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (want.hit) hits++;
                    if (got != want || i_m_tdata[7]) note_mismatch(want, i_m_tdata, 1'b0);
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

FILE: dv/kmp_stream_matcher_core_test.sv
// Testbench top for kmp_stream_matcher_core: drives text words and register writes,
// stalls the result side, and reports the verdict. Depends on ksm_pkg, kmp_stream_matcher_core and kmp_match_checker.
module kmp_stream_matcher_core_test;

    localparam int MAX_PAT        = 16;
    localparam int RANDOM_WORDS   = 1500;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [ksm_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [ksm_pkg::CFG_IDX_W-1:0]  i_cfg_idx = ksm_pkg::CFG_PATTERN_LENGTH;
    logic [ksm_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [7:0]                     m_axis_tdata;

    int mismatches;
    int pending;
    int checked;
    int hits;

    int words_sent   = 0;
    int random_words = 0;
    int cfg_writes   = 0;
    int phases       = 0;
    int burst_left   = 0;
    bit valid_up     = 1'b0;
    int phase_pos    = 0;
    bit lead_first   = 1'b0;

    logic [7:0] pat_bytes [16];
    logic [7:0] alph [4];
    int         alph_n = 1;
    int         pat_n  = 1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    kmp_stream_matcher_core #(.MAX_PATTERN(MAX_PAT)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    kmp_match_checker #(.MAX_PATTERN(MAX_PAT)) match_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits)
    );

    // Result-side backpressure: the stall mode is picked anew whenever its run count expires.
    t_rx_mode rx_mode   = RX_OPEN;
    int       rx_count  = 0;
    int       rx_phase  = 0;
    int       rx_period = 2;
    int       rx_stall  = 1;

    always @(negedge i_clk) begin
        if (rx_count == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            rx_count  = $urandom_range(50, 300);
            rx_period = $urandom_range(2, 12);
            rx_stall  = $urandom_range(1, rx_period - 1);
            rx_phase  = 0;
        end
        rx_count--;
        rx_phase = (rx_phase + 1) % rx_period;
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 9) < 7);
            RX_PERIODIC: m_axis_tready <= (rx_phase >= rx_stall);
            default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d cycles without a transfer", WATCHDOG_LIMIT);
            $display("FAIL kmp_stream_matcher_core");
            $finish;
        end
    end

    // Called at a falling edge; returns at a falling edge.
    task automatic send_word(input logic [7:0] c, input logic first);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= first;
        valid_up = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = $urandom_range(0, 40);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                valid_up = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic emit(input logic [7:0] c);
        logic f;
        f = (phase_pos == 0) ? lead_first : ($urandom_range(0, 49) == 0);
        send_word(c, f);
        phase_pos++;
        random_words++;
    endtask

    // Drain every outstanding result before touching the registers.
    task automatic settle();
        if (valid_up) begin
            s_axis_tvalid <= 1'b0;
            valid_up = 1'b0;
        end
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [ksm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ksm_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
        // row may replay pattern bytes after a write
        repeat (17) @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
    endtask

    task automatic load_pattern(input logic [4:0] raw, input bit len_only);
        logic [63:0] lo;
        logic [63:0] hi;
        for (int j = 0; j < 8; j++) begin
            lo[8*j +: 8] = pat_bytes[j];
            hi[8*j +: 8] = pat_bytes[j+8];
        end
        pat_n = (raw == 0) ? 1 : ((raw > 16) ? 16 : raw);
        if (len_only) begin
            cfg_write(ksm_pkg::CFG_PATTERN_LENGTH, 64'(raw));
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    cfg_write(ksm_pkg::CFG_PATTERN_LENGTH, 64'(raw));
                    cfg_write(ksm_pkg::CFG_PATTERN_LOW, lo);
                    cfg_write(ksm_pkg::CFG_PATTERN_HIGH, hi);
                end
                1: begin
                    cfg_write(ksm_pkg::CFG_PATTERN_LOW, lo);
                    cfg_write(ksm_pkg::CFG_PATTERN_HIGH, hi);
                    cfg_write(ksm_pkg::CFG_PATTERN_LENGTH, 64'(raw));
                end
                default: begin
                    cfg_write(ksm_pkg::CFG_PATTERN_HIGH, hi);
                    cfg_write(ksm_pkg::CFG_PATTERN_LENGTH, 64'(raw));
                    cfg_write(ksm_pkg::CFG_PATTERN_LOW, lo);
                end
            endcase
        end
    endtask

    initial begin
        logic [4:0] raw;
        int         n_items;
        int         sel;
        int         cut;
        int         fill;
        bit         len_only;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: one byte, value zero
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        settle();

        // length zero acts as one
        cfg_write(ksm_pkg::CFG_PATTERN_LENGTH, 64'd0);
        cfg_write(ksm_pkg::CFG_PATTERN_LOW, 64'h0000_0000_0000_00FF);
        send_word(8'hFF, 1'b1);
        send_word(8'h7E, 1'b0);
        send_word(8'hFF, 1'b0);
        settle();

        // oversize length saturates to 16; a run of one byte overlaps
        cfg_write(ksm_pkg::CFG_PATTERN_LENGTH, 64'd31);
        cfg_write(ksm_pkg::CFG_PATTERN_LOW, {8{8'hAA}});
        cfg_write(ksm_pkg::CFG_PATTERN_HIGH, {8{8'hAA}});
        for (int j = 0; j < 17; j++) send_word(8'hAA, (j == 0));
        settle();

        // length cut and restored with no text between: held progress survives
        cfg_write(ksm_pkg::CFG_PATTERN_LENGTH, 64'd3);
        cfg_write(ksm_pkg::CFG_PATTERN_LENGTH, 64'd16);
        send_word(8'hAA, 1'b0);
        settle();

        // shorter pattern mid-text: held progress is past the new length
        cfg_write(ksm_pkg::CFG_PATTERN_LENGTH, 64'd3);
        cfg_write(ksm_pkg::CFG_PATTERN_LOW, 64'h0000_0000_0061_6261);
        cfg_write(CFG_SPARE_IDX, {$urandom, $urandom});
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b0);
        send_word(8'h61, 1'b0);

        while (random_words < RANDOM_WORDS) begin
            settle();
            phases++;
            alph_n = $urandom_range(1, 4);
            for (int j = 0; j < 4; j++) alph[j] = 8'($urandom);
            case ($urandom_range(0, 9))
                0:       raw = 5'd0;
                1:       raw = 5'd16;
                2:       raw = 5'($urandom_range(17, 31));
                3, 4:    raw = 5'($urandom_range(7, 15));
                default: raw = 5'($urandom_range(1, 6));
            endcase
            len_only = (phases > 1) && ($urandom_range(0, 3) == 0);
            if (!len_only) begin
                fill = $urandom_range(0, 9);
                for (int j = 0; j < 16; j++) begin
                    if (fill == 0) pat_bytes[j] = 8'h00;
                    else if (fill == 1) pat_bytes[j] = 8'hFF;
                    else pat_bytes[j] = alph[$urandom_range(0, alph_n - 1)];
                end
            end
            load_pattern(raw, len_only);

            n_items    = $urandom_range(30, 120);
            phase_pos  = 0;
            lead_first = ($urandom_range(0, 3) != 0);
            while (phase_pos < n_items) begin
                sel = $urandom_range(0, 99);
                if (sel < 30) begin
                    cut = $urandom_range(0, 1) ? pat_n : $urandom_range(1, pat_n);
                    for (int j = 0; j < cut && phase_pos < n_items; j++) emit(pat_bytes[j]);
                end else if (sel < 88) begin
                    emit(alph[$urandom_range(0, alph_n - 1)]);
                end else begin
                    emit(8'($urandom_range(0, 255)));
                end
            end
        end

        settle();
        repeat (10) @(negedge i_clk);
        $display("ran %0d text words over %0d random setups with %0d register writes",
                 words_sent, phases, cfg_writes);
        $display("checked %0d result words, %0d of them hits, %0d mismatches",
                 checked, hits, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS kmp_stream_matcher_core");
        end else begin
            $display("FAIL kmp_stream_matcher_core");
        end
        $finish;
    end

endmodule
